FILE: rtl/core/kcc_pkg.sv
// Shared types and constants for the key click classifier.
package kcc_pkg;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int DBNC_W      = 8;
    localparam int TIMEOUT_W   = 24;
    localparam int KIND_W      = 2;
    localparam int WAIT_W_DEF  = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_DEBOUNCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_MIN          = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_TIMEOUT   = 2'd3;

    localparam logic [DBNC_W-1:0]    PRESS_DEBOUNCE_RST   = 8'd200;
    localparam logic [DBNC_W-1:0]    RELEASE_DEBOUNCE_RST = 8'd100;
    localparam logic [DBNC_W-1:0]    GAP_MIN_RST          = 8'd10;
    localparam logic [TIMEOUT_W-1:0] DOUBLE_TIMEOUT_RST   = 24'd50000;

    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DOUBLE = 2'd2;

    typedef enum logic [1:0] {
        STEP_IDLE    = 2'd0,
        STEP_WAIT2   = 2'd1,
        STEP_WAIT_UP = 2'd2,
        STEP_REPORT  = 2'd3
    } t_step;

    typedef struct packed {
        logic [DBNC_W-1:0]    press_debounce;
        logic [DBNC_W-1:0]    release_debounce;
        logic [DBNC_W-1:0]    gap_min;
        logic [TIMEOUT_W-1:0] double_timeout;
    } t_cfg;

    typedef struct packed {
        logic              event_valid;
        logic [KIND_W-1:0] click_kind;
    } t_result;

endpackage

FILE: rtl/core/key_click_classifier_core.sv
// Top level of the key click classifier: stream ports, sample and result registers.
//
// Usage:
//   Slave stream carries one button sample per transfer (tdata[0] = key_pressed,
//   1 while the pin is low). Master stream returns exactly one result per sample:
//   tdata[0] = event_valid, tdata[2:1] = click_kind (1 single, 2 double, 0 none).
//   The config port writes press_debounce (0), release_debounce (1), gap_min (2)
//   and double_timeout (3) on any cycle with i_cfg_we high; write only while idle.
// Timing:
//   A sample goes into the input register and is classified against the click
//   state in a cycle in which the output register is free; the result and the
//   new state are registered at the end of that cycle. One sample per cycle is
//   sustained while i_m_axis_tready stays high; the per-sample state update sets that rate.
// Reset:
//   Synchronous, active low. Clears the click state, both pipeline valids, and
//   loads the default register values (200, 100, 10, 50000).
// Stall:
//   With i_m_axis_tready low the result holds; the input register still takes
//   one more sample, then o_s_axis_tready drops until the result is taken.
module key_click_classifier_core
    import kcc_pkg::*;
#(
    parameter int WAIT_WIDTH = WAIT_W_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,  // [0] key_pressed, [7:1] zero
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [7:0]            o_m_axis_tdata,  // [0] event_valid, [2:1] click_kind
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg    cfg;
    t_result step_result;

    logic    r_in_valid;
    logic    r_in_key;
    logic    r_out_valid;
    t_result r_out;

    logic    out_free;
    logic    step_en;
    logic    in_take;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign step_en         = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    kcc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    kcc_fsm #(
        .WAIT_WIDTH (WAIT_WIDTH)
    ) u_fsm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_step_en     (step_en),
        .i_key_pressed (r_in_key),
        .o_result      (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (step_en) begin
                r_in_valid <= 1'b0;
            end
            if (step_en) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_key <= i_s_axis_tdata[0];
        end
        if (step_en) begin
            r_out <= step_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_out.click_kind, r_out.event_valid};

endmodule

FILE: rtl/core/kcc_cfg.sv
// Configuration register bank for the key click classifier.
module kcc_cfg
    import kcc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_PRESS_DEBOUNCE:   n_cfg.press_debounce   = i_cfg_wdata[DBNC_W-1:0];
                CFG_RELEASE_DEBOUNCE: n_cfg.release_debounce = i_cfg_wdata[DBNC_W-1:0];
                CFG_GAP_MIN:          n_cfg.gap_min          = i_cfg_wdata[DBNC_W-1:0];
                CFG_DOUBLE_TIMEOUT:   n_cfg.double_timeout   = i_cfg_wdata[TIMEOUT_W-1:0];
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_debounce   <= PRESS_DEBOUNCE_RST;
            r_cfg.release_debounce <= RELEASE_DEBOUNCE_RST;
            r_cfg.gap_min          <= GAP_MIN_RST;
            r_cfg.double_timeout   <= DOUBLE_TIMEOUT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/core/kcc_fsm.sv
// Click classification state machine with debounce and wait counters.
module kcc_fsm
    import kcc_pkg::*;
#(
    parameter int WAIT_WIDTH = WAIT_W_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_step_en,
    input  logic    i_key_pressed,
    output t_result o_result
);

    localparam int CMP_W = (WAIT_WIDTH > TIMEOUT_W) ? WAIT_WIDTH : TIMEOUT_W;

    t_step                 r_step,    n_step;
    logic [DBNC_W-1:0]     r_press,   n_press;
    logic [DBNC_W-1:0]     r_release, n_release;
    logic [WAIT_WIDTH-1:0] r_wait,    n_wait;
    logic [KIND_W-1:0]     r_record,  n_record;

    logic [DBNC_W-1:0]     press_inc;
    logic [DBNC_W-1:0]     release_inc;
    logic [WAIT_WIDTH-1:0] wait_inc;
    logic                  timeout_hit;

    // saturating increments
    assign press_inc   = (&r_press)   ? r_press   : r_press + 1'b1;
    assign release_inc = (&r_release) ? r_release : r_release + 1'b1;
    assign wait_inc    = (&r_wait)    ? r_wait    : r_wait + 1'b1;
    assign timeout_hit = CMP_W'(wait_inc) >= CMP_W'(i_cfg.double_timeout);

    // next state
    always_comb begin
        n_step    = r_step;
        n_press   = r_press;
        n_release = r_release;
        n_wait    = r_wait;
        n_record  = r_record;
        case (r_step)
            STEP_IDLE: begin
                if (i_key_pressed) begin
                    n_press = press_inc;
                    if (press_inc >= i_cfg.press_debounce) begin
                        n_record = KIND_SINGLE;
                    end
                end else if (r_record == KIND_SINGLE) begin
                    n_release = '0;
                    n_press   = '0;
                    n_wait    = '0;
                    n_step    = STEP_WAIT2;
                end else begin
                    n_press   = '0;
                    n_release = '0;
                end
            end
            STEP_WAIT2: begin
                if (i_key_pressed) begin
                    if (r_release < i_cfg.gap_min) begin
                        n_release = '0;
                    end else begin
                        n_press = press_inc;
                        if (press_inc >= i_cfg.press_debounce) begin
                            n_record  = KIND_DOUBLE;
                            n_release = '0;
                            n_step    = STEP_WAIT_UP;
                        end
                    end
                end else begin
                    n_release = release_inc;
                    n_wait    = wait_inc;
                    if (timeout_hit) begin
                        n_wait    = '0;
                        n_release = '0;
                        n_press   = '0;
                        n_step    = STEP_REPORT;
                    end
                end
            end
            STEP_WAIT_UP: begin
                if (i_key_pressed) begin
                    n_release = '0;
                end else begin
                    n_release = release_inc;
                    if (release_inc >= i_cfg.release_debounce) begin
                        n_step = STEP_REPORT;
                    end
                end
            end
            default: begin
                n_wait    = '0;
                n_release = '0;
                n_press   = '0;
                n_record  = KIND_NONE;
                n_step    = STEP_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_result.event_valid = 1'b0;
        o_result.click_kind  = KIND_NONE;
        case (r_step)
            STEP_REPORT: begin
                o_result.event_valid = 1'b1;
                o_result.click_kind  = r_record;
            end
            default: begin
                o_result.event_valid = 1'b0;
                o_result.click_kind  = KIND_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= STEP_IDLE;
            r_press   <= '0;
            r_release <= '0;
            r_wait    <= '0;
            r_record  <= KIND_NONE;
        end else if (i_step_en) begin
            r_step    <= n_step;
            r_press   <= n_press;
            r_release <= n_release;
            r_wait    <= n_wait;
            r_record  <= n_record;
        end
    end

endmodule

FILE: tb/sv/key_click_classifier_core_test.sv
// Self-checking testbench for key_click_classifier_core: stream samples in, click results checked.
module key_click_classifier_core_test
    import kcc_pkg::*;
();

    class click_tracker;
        t_cfg                  cfg;
        t_step                 step;
        logic [DBNC_W-1:0]     press_cnt;
        logic [DBNC_W-1:0]     release_cnt;
        logic [WAIT_W_DEF-1:0] wait_cnt;
        logic [KIND_W-1:0]     record;
        t_result               pending_results[$];
        int                    errors;
        int                    results_seen;

        function new();
            cfg.press_debounce   = PRESS_DEBOUNCE_RST;
            cfg.release_debounce = RELEASE_DEBOUNCE_RST;
            cfg.gap_min          = GAP_MIN_RST;
            cfg.double_timeout   = DOUBLE_TIMEOUT_RST;
            step         = STEP_IDLE;
            press_cnt    = '0;
            release_cnt  = '0;
            wait_cnt     = '0;
            record       = KIND_NONE;
            errors       = 0;
            results_seen = 0;
        endfunction

        task report(input string what);
            errors++;
            if (errors <= 50) begin
                $display("ERROR: %s", what);
            end
        endtask

        function void set_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_PRESS_DEBOUNCE:   cfg.press_debounce   = val[DBNC_W-1:0];
                CFG_RELEASE_DEBOUNCE: cfg.release_debounce = val[DBNC_W-1:0];
                CFG_GAP_MIN:          cfg.gap_min          = val[DBNC_W-1:0];
                CFG_DOUBLE_TIMEOUT:   cfg.double_timeout   = val[TIMEOUT_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [DBNC_W-1:0] bump8(input logic [DBNC_W-1:0] v);
            return (&v) ? v : v + 1'b1;
        endfunction

        function logic [WAIT_W_DEF-1:0] bump_wait(input logic [WAIT_W_DEF-1:0] v);
            return (&v) ? v : v + 1'b1;
        endfunction

        function t_result classify_sample(input bit key);
            t_result r;
            r.event_valid = 1'b0;
            r.click_kind  = KIND_NONE;
            case (step)
                STEP_IDLE: begin
                    if (key) begin
                        press_cnt = bump8(press_cnt);
                        if (press_cnt >= cfg.press_debounce) begin
                            record = KIND_SINGLE;
                        end
                    end else if (record == KIND_SINGLE) begin
                        release_cnt = '0;
                        press_cnt   = '0;
                        wait_cnt    = '0;
                        step        = STEP_WAIT2;
                    end else begin
                        press_cnt   = '0;
                        release_cnt = '0;
                    end
                end
                STEP_WAIT2: begin
                    if (key) begin
                        if (release_cnt < cfg.gap_min) begin
                            release_cnt = '0;
                        end else begin
                            press_cnt = bump8(press_cnt);
                            if (press_cnt >= cfg.press_debounce) begin
                                record      = KIND_DOUBLE;
                                release_cnt = '0;
                                step        = STEP_WAIT_UP;
                            end
                        end
                    end else begin
                        release_cnt = bump8(release_cnt);
                        wait_cnt    = bump_wait(wait_cnt);
                        if (wait_cnt >= cfg.double_timeout) begin
                            wait_cnt    = '0;
                            release_cnt = '0;
                            press_cnt   = '0;
                            step        = STEP_REPORT;
                        end
                    end
                end
                STEP_WAIT_UP: begin
                    if (key) begin
                        release_cnt = '0;
                    end else begin
                        release_cnt = bump8(release_cnt);
                        if (release_cnt >= cfg.release_debounce) begin
                            step = STEP_REPORT;
                        end
                    end
                end
                default: begin
                    r.event_valid = 1'b1;
                    r.click_kind  = record;
                    record        = KIND_NONE;
                    wait_cnt      = '0;
                    release_cnt   = '0;
                    press_cnt     = '0;
                    step          = STEP_IDLE;
                end
            endcase
            return r;
        endfunction

        function void note_sample(input bit key);
            pending_results.push_back(classify_sample(key));
        endfunction

        task check_result(input logic [7:0] data);
            t_result want;
            results_seen++;
            if (pending_results.size() == 0) begin
                report($sformatf("result %0d: transfer 0x%02h with nothing expected",
                                 results_seen, data));
                return;
            end
            want = pending_results.pop_front();
            if (data[0] !== want.event_valid) begin
                report($sformatf("result %0d: event_valid %b, expected %b",
                                 results_seen, data[0], want.event_valid));
            end
            if (data[2:1] !== want.click_kind) begin
                report($sformatf("result %0d: click_kind %0d, expected %0d",
                                 results_seen, data[2:1], want.click_kind));
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [7:0]            s_tdata   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [7:0]            o_m_axis_tdata;

    bit           idle_on = 1'b1;
    t_cfg         cur_cfg;
    click_tracker tracker = new();

    key_click_classifier_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),    // [0] key_pressed, [7:1] zero
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata), // [0] event_valid, [2:1] click_kind
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #800000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tready && o_m_axis_tvalid) begin
                tracker.check_result(o_m_axis_tdata);
            end
            m_tready <= !(idle_on && $urandom_range(99) < 13);
        end
    end

    task automatic send_sample(input bit key);
        while (idle_on && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, key};
        do @(posedge i_clk); while (!o_s_axis_tready);
        tracker.note_sample(key);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg c);
        logic [CFG_IDX_W-1:0]  idx[4];
        logic [CFG_DATA_W-1:0] val[4];
        idx[0] = CFG_PRESS_DEBOUNCE;   val[0] = CFG_DATA_W'(c.press_debounce);
        idx[1] = CFG_RELEASE_DEBOUNCE; val[1] = CFG_DATA_W'(c.release_debounce);
        idx[2] = CFG_GAP_MIN;          val[2] = CFG_DATA_W'(c.gap_min);
        idx[3] = CFG_DOUBLE_TIMEOUT;   val[3] = CFG_DATA_W'(c.double_timeout);
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= idx[i];
            cfg_wdata <= val[i];
            @(posedge i_clk);
            tracker.set_cfg(idx[i], val[i]);
        end
        cfg_we  <= 1'b0;
        cur_cfg = c;
    endtask

    // press runs sit around the debounce length, release runs around gap,
    // release debounce or timeout (capped at 400), or are short, so the machine reaches every step
    function automatic int run_length(input bit lvl);
        int base;
        if (lvl) begin
            base = int'(cur_cfg.press_debounce);
            if ($urandom_range(3) == 0) begin
                base = base + 50;
            end
        end else begin
            case ($urandom_range(3))
                0: base = int'(cur_cfg.gap_min);
                1: base = int'(cur_cfg.release_debounce);
                2: base = (cur_cfg.double_timeout > 400) ? 400 : int'(cur_cfg.double_timeout);
                default: base = int'($urandom_range(1, 4));
            endcase
        end
        base = base + int'($urandom_range(0, 3)) - 1;
        return (base < 1) ? 1 : base;
    endfunction

    task automatic play_runs(input int budget);
        int sent;
        int len;
        bit lvl;
        sent = 0;
        lvl  = 1'b1;
        while (sent < budget) begin
            if ($urandom_range(99) < 15) begin
                len = int'($urandom_range(1, 6));
                repeat (len) send_sample(1'($urandom_range(1)));
            end else begin
                len = run_length(lvl);
                repeat (len) send_sample(lvl);
                lvl = !lvl;
            end
            sent += len;
        end
    endtask

    initial begin
        t_cfg c;
        bit   seq[$];
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: a short press is far below the debounce
        send_sample(1'b1);
        send_sample(1'b1);
        send_sample(1'b0);
        drain();

        // single and double click, short gap, first release without debounce
        c.press_debounce   = 8'd1;
        c.release_debounce = 8'd1;
        c.gap_min          = 8'd2;
        c.double_timeout   = 24'd4;
        write_cfg(c);
        seq = '{1, 0, 1, 0, 0, 1, 1, 0, 0, 1, 0, 0, 0, 0, 0, 0};
        foreach (seq[i]) send_sample(seq[i]);
        drain();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin
                    c.press_debounce   = PRESS_DEBOUNCE_RST;
                    c.release_debounce = RELEASE_DEBOUNCE_RST;
                    c.gap_min          = GAP_MIN_RST;
                    c.double_timeout   = DOUBLE_TIMEOUT_RST;
                end
                1: begin
                    c.press_debounce   = 8'd1;
                    c.release_debounce = 8'd1;
                    c.gap_min          = 8'd0;
                    c.double_timeout   = 24'd1;
                end
                2: begin
                    c.press_debounce   = 8'hFF;
                    c.release_debounce = 8'hFF;
                    c.gap_min          = 8'hFF;
                    c.double_timeout   = 24'hFFFFFF;
                end
                default: begin
                    c.press_debounce   = DBNC_W'($urandom_range(1, 8));
                    c.release_debounce = DBNC_W'($urandom_range(1, 8));
                    c.gap_min          = DBNC_W'($urandom_range(0, 6));
                    c.double_timeout   = TIMEOUT_W'($urandom_range(1, 24));
                end
            endcase
            write_cfg(c);
            idle_on = (p != 2);
            play_runs((p == 0) ? 150 : (p == 2) ? 200 : 15);
            drain();
        end

        idle_on = 1'b1;
        if (tracker.pending_results.size() != 0) begin
            tracker.report($sformatf("%0d expected results never arrived",
                                     tracker.pending_results.size()));
        end
        if (tracker.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
